FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the cache model RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/salc_pkg.sv
`timescale 1ns / 1ps
package salc_pkg;
	localparam int MaxSetBits = 8;
	localparam int MaxWays = 8;
	localparam int CountWidth = 32;
	localparam int AgeMax = 7;

	typedef enum logic [1:0] {
		ACT_LS = 2'd0,
		ACT_MODIFY = 2'd1,
		ACT_IFETCH = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		OUT_HIT = 2'd0,
		OUT_MISS = 2'd1,
		OUT_EVICT = 2'd2
	} outcome_t;

	typedef enum logic [1:0] {
		REG_SET_BITS = 2'd0,
		REG_BLOCK_BITS = 2'd1,
		REG_WAYS = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_READ,
		BK_UPDATE
	} bk_state_t;
endpackage

FILE: hw/rtl/salc_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Splits an accepted item into accesses and queues them.
module salc_front #(
	parameter int MAX_SET_BITS = salc_pkg::MaxSetBits
) (
	input  logic clk,
	input  logic arst_n,
	input  logic take,
	input  logic [1:0] action,
	input  logic [63:0] address,
	input  logic [3:0] set_bits,
	input  logic [5:0] block_bits,
	input  logic pop,
	output logic q_valid,
	output logic q_last,
	output logic [MAX_SET_BITS-1:0] q_set,
	output logic [63:0] q_tag,
	output logic full
);
	logic [1:0] cnt_q;
	logic last_q [2];
	logic [MAX_SET_BITS-1:0] set_q [2];
	logic [63:0] tag_q [2];
	logic [3:0] sb;
	logic [6:0] shift;
	logic [63:0] above;
	logic [63:0] tag;
	logic [63:0] mask;
	logic [MAX_SET_BITS-1:0] si;
	logic n_acc;

	always_comb begin
		sb = (set_bits > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : set_bits;
		shift = 7'(block_bits) + 7'(sb);
		above = address >> block_bits;
		tag = shift[6] ? 64'd0 : (address >> shift[5:0]);
		mask = (64'd1 << sb) - 64'd1;
		si = MAX_SET_BITS'(above & mask);
	end

	assign n_acc = (salc_pkg::action_t'(action) == salc_pkg::ACT_MODIFY);
	assign full = (cnt_q != 2'd0);
	assign q_valid = full;
	assign q_last = last_q[0];
	assign q_set = set_q[0];
	assign q_tag = tag_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (take) begin
			case (salc_pkg::action_t'(action))
				salc_pkg::ACT_LS: cnt_q <= 2'd1;
				salc_pkg::ACT_MODIFY: cnt_q <= 2'd2;
				default: cnt_q <= 2'd0;
			endcase
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			set_q[0] <= si;
			set_q[1] <= si;
			tag_q[0] <= tag;
			tag_q[1] <= tag;
			last_q[0] <= !n_acc;
			last_q[1] <= 1'b1;
		end else if (pop) begin
			set_q[0] <= set_q[1];
			tag_q[0] <= tag_q[1];
			last_q[0] <= last_q[1];
		end
	end

	`ASSERT_IMPL(a_no_take_full, clk, arst_n, take, cnt_q == 2'd0, "take while queue busy")
	`ASSERT_IMPL(a_pop_valid, clk, arst_n, pop, cnt_q != 2'd0, "pop from empty queue")
endmodule

FILE: hw/rtl/salc_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Looks up one set, picks hit/free/victim way and updates tags, ages and totals.
module salc_back #(
	parameter int MAX_SET_BITS = salc_pkg::MaxSetBits,
	parameter int MAX_WAYS = salc_pkg::MaxWays,
	parameter int COUNT_WIDTH = salc_pkg::CountWidth
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  logic q_last,
	input  logic [MAX_SET_BITS-1:0] q_set,
	input  logic [63:0] q_tag,
	input  logic [3:0] ways_in_use,
	output logic pop,
	output logic busy,
	output logic strobe,
	output logic [1:0] outcome,
	output logic [7:0] set_index,
	output logic last,
	output logic [31:0] hit_total,
	output logic [31:0] miss_total,
	output logic [31:0] eviction_total
);
	localparam int Sets = 1 << MAX_SET_BITS;
	localparam int WW = $clog2(MAX_WAYS + 1);
	localparam int WI = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

	// One row per set, all ways side by side.
	logic [MAX_WAYS-1:0] val_mem [Sets];
	logic [MAX_WAYS*64-1:0] tag_mem [Sets];
	logic [MAX_WAYS*3-1:0] age_mem [Sets];

	salc_pkg::bk_state_t state_q, state_d;
	logic [MAX_SET_BITS:0] clr_q;
	logic [MAX_SET_BITS-1:0] set_q;
	logic [63:0] tag_q;
	logic last_q;
	logic [MAX_WAYS-1:0] val_rd;
	logic [MAX_WAYS*64-1:0] tag_rd;
	logic [MAX_WAYS*3-1:0] age_rd;
	logic [COUNT_WIDTH-1:0] hits_q, miss_q, evic_q;

	logic [WW-1:0] nways;
	logic [MAX_WAYS-1:0] in_use, hitv;
	logic hit, allv;
	logic [WI-1:0] way;
	logic [2:0] old_age, best;
	logic [1:0] oc;
	logic [MAX_WAYS-1:0] val_new;
	logic [MAX_WAYS*64-1:0] tag_new;
	logic [MAX_WAYS*3-1:0] age_new;
	logic found;
	logic [2:0] a;
	logic wr;

	always_comb begin
		nways = (ways_in_use == 4'd0) ? WW'(1)
			: ((32'(ways_in_use) > MAX_WAYS) ? WW'(MAX_WAYS) : WW'(ways_in_use));
		for (int w = 0; w < MAX_WAYS; w++) begin
			in_use[w] = (w < 32'(nways));
			hitv[w] = in_use[w] && val_rd[w] && (tag_rd[w*64 +: 64] == tag_q);
		end
		hit = |hitv;
		allv = &(val_rd | ~in_use);
		way = '0;
		found = 1'b0;
		best = 3'd0;
		if (hit) begin
			for (int w = 0; w < MAX_WAYS; w++)
				if (hitv[w] && !found) begin
					way = WI'(w);
					found = 1'b1;
				end
			old_age = age_rd[way*3 +: 3];
			oc = salc_pkg::OUT_HIT;
		end else if (allv) begin
			for (int w = 0; w < MAX_WAYS; w++)
				if (in_use[w] && (w == 0 || age_rd[w*3 +: 3] > best)) begin
					best = age_rd[w*3 +: 3];
					way = WI'(w);
				end
			old_age = best;
			oc = salc_pkg::OUT_EVICT;
		end else begin
			for (int w = 0; w < MAX_WAYS; w++)
				if (in_use[w] && !val_rd[w] && !found) begin
					way = WI'(w);
					found = 1'b1;
				end
			old_age = 3'd7;
			oc = salc_pkg::OUT_MISS;
		end
		val_new = val_rd;
		tag_new = tag_rd;
		age_new = age_rd;
		val_new[way] = 1'b1;
		if (!hit)
			tag_new[way*64 +: 64] = tag_q;
		for (int w = 0; w < MAX_WAYS; w++) begin
			a = age_rd[w*3 +: 3];
			// Free-way fill ages every valid in-use way below AgeMax; compare as old_age+1 = 8.
			if (WI'(w) != way && in_use[w] && val_rd[w]
				&& ((oc == salc_pkg::OUT_MISS) || a < old_age) && a < 3'(salc_pkg::AgeMax))
				age_new[w*3 +: 3] = a + 3'd1;
		end
		age_new[way*3 +: 3] = 3'd0;
	end

	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		wr = 1'b0;
		case (state_q)
			salc_pkg::BK_CLEAR:
				if (clr_q == (MAX_SET_BITS+1)'(Sets - 1)) state_d = salc_pkg::BK_IDLE;
			salc_pkg::BK_IDLE:
				if (q_valid) begin
					pop = 1'b1;
					state_d = salc_pkg::BK_READ;
				end
			salc_pkg::BK_READ: state_d = salc_pkg::BK_UPDATE;
			salc_pkg::BK_UPDATE: begin
				wr = 1'b1;
				state_d = salc_pkg::BK_IDLE;
			end
			default: state_d = salc_pkg::BK_IDLE;
		endcase
	end

	assign busy = (state_q != salc_pkg::BK_IDLE) || q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= salc_pkg::BK_CLEAR;
			clr_q <= '0;
			hits_q <= '0;
			miss_q <= '0;
			evic_q <= '0;
			strobe <= 1'b0;
		end else begin
			state_q <= state_d;
			strobe <= wr;
			if (state_q == salc_pkg::BK_CLEAR) clr_q <= clr_q + 1'b1;
			if (wr) begin
				if (oc == salc_pkg::OUT_HIT) begin
					if (~&hits_q) hits_q <= hits_q + 1'b1;
				end else begin
					if (~&miss_q) miss_q <= miss_q + 1'b1;
					if (oc == salc_pkg::OUT_EVICT && ~&evic_q) evic_q <= evic_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			set_q <= q_set;
			tag_q <= q_tag;
			last_q <= q_last;
		end
		if (state_q == salc_pkg::BK_READ) begin
			val_rd <= val_mem[set_q];
			tag_rd <= tag_mem[set_q];
			age_rd <= age_mem[set_q];
		end
		if (state_q == salc_pkg::BK_CLEAR) begin
			val_mem[clr_q[MAX_SET_BITS-1:0]] <= '0;
			age_mem[clr_q[MAX_SET_BITS-1:0]] <= '0;
		end else if (wr) begin
			val_mem[set_q] <= val_new;
			tag_mem[set_q] <= tag_new;
			age_mem[set_q] <= age_new;
		end
		if (wr) begin
			outcome <= oc;
			set_index <= 8'(set_q);
			last <= last_q;
		end
	end

	assign hit_total = 32'(hits_q);
	assign miss_total = 32'(miss_q);
	assign eviction_total = 32'(evic_q);

	`ASSERT_IMPL(a_strobe_after_upd, clk, arst_n, strobe, $past(state_q) == salc_pkg::BK_UPDATE,
		"strobe without update")
	`ASSERT_IMPL(a_evict_counts, clk, arst_n, wr && oc == salc_pkg::OUT_EVICT,
		##1 (evic_q != $past(evic_q) || &evic_q), "eviction not counted")
endmodule

FILE: hw/rtl/set_assoc_lru_cache_model.sv
`timescale 1ns / 1ps
// Each result strobe is registered from the update state; a load or store gives one, a modify two.
// An ignored action gives none. A load or store passes pop, set read and update before the back end
// is idle again, a modify passes them twice, and busy holds a new request off until then. After reset
// a clearing pass sweeps 2^MAX_SET_BITS set rows; busy stays high meanwhile. Results cannot be stalled by the receiver.
module set_assoc_lru_cache_model #(
	parameter int MAX_SET_BITS = salc_pkg::MaxSetBits,
	parameter int MAX_WAYS = salc_pkg::MaxWays,
	parameter int COUNT_WIDTH = salc_pkg::CountWidth
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [1:0] action,
	input  logic [63:0] address,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [5:0] cfg_data,
	output logic strobe,
	output logic [1:0] outcome,
	output logic [7:0] set_index,
	output logic last,
	output logic [31:0] hit_total,
	output logic [31:0] miss_total,
	output logic [31:0] eviction_total
);
	logic [3:0] set_bits_q, ways_q;
	logic [5:0] block_bits_q;
	logic take, pop, q_valid, q_last, full, bk_busy;
	logic [MAX_SET_BITS-1:0] q_set;
	logic [63:0] q_tag;

	assign busy = full || bk_busy;
	assign take = start && !busy;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q <= 4'd4;
			block_bits_q <= 6'd4;
			ways_q <= 4'd1;
		end else if (cfg_valid) begin
			case (salc_pkg::reg_idx_t'(cfg_index))
				salc_pkg::REG_SET_BITS: set_bits_q <= cfg_data[3:0];
				salc_pkg::REG_BLOCK_BITS: block_bits_q <= cfg_data;
				salc_pkg::REG_WAYS: ways_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	salc_front #(.MAX_SET_BITS(MAX_SET_BITS)) u_front (
		.clk, .arst_n, .take, .action, .address,
		.set_bits(set_bits_q), .block_bits(block_bits_q),
		.pop, .q_valid, .q_last, .q_set, .q_tag, .full
	);

	salc_back #(.MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
		.clk, .arst_n, .q_valid, .q_last, .q_set, .q_tag,
		.ways_in_use(ways_q), .pop, .busy(bk_busy), .strobe, .outcome, .set_index,
		.last, .hit_total, .miss_total, .eviction_total
	);
endmodule

FILE: dv/salc_checker.sv
`timescale 1ns / 1ps
module salc_checker
	import salc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  logic [1:0] action,
	input  logic [63:0] address,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [5:0] cfg_data,
	input  logic strobe,
	input  logic [1:0] outcome,
	input  logic [7:0] set_index,
	input  logic last,
	input  logic [31:0] hit_total,
	input  logic [31:0] miss_total,
	input  logic [31:0] eviction_total,
	output int errors,
	output int pending,
	output int checked
);
	localparam int NumSets = 1 << MaxSetBits;

	typedef struct {
		outcome_t oc;
		logic [7:0] si;
		logic lst;
		logic [31:0] hits;
		logic [31:0] misses;
		logic [31:0] evicts;
	} access_result_t;

	access_result_t result_q[$];

	logic [3:0] set_bits_r;
	logic [5:0] block_bits_r;
	logic [3:0] ways_r;
	logic line_ok[NumSets][MaxWays];
	logic [63:0] line_tg[NumSets][MaxWays];
	logic [2:0] line_rank[NumSets][MaxWays];
	logic [31:0] hits_r, misses_r, evicts_r;

	assign pending = result_q.size();

	function automatic logic [31:0] bump(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	// Promote way w to most recent; ways younger than old_rank age by one.
	function automatic void promote(input int s, input int w, input int nw, input int old_rank);
		for (int v = 0; v < nw; v++)
			if (v != w && line_ok[s][v] && line_rank[s][v] < old_rank && line_rank[s][v] < AgeMax)
				line_rank[s][v] = line_rank[s][v] + 3'd1;
		line_rank[s][w] = 3'd0;
	endfunction

	function automatic void cache_lookup(input logic [63:0] a, output outcome_t oc,
			output logic [7:0] si);
		int sbe, nw, shift, s, occupied, victim, best;
		logic [63:0] tg, above;
		sbe = (set_bits_r > MaxSetBits) ? MaxSetBits : set_bits_r;
		nw = (ways_r == 0) ? 1 : ((ways_r > MaxWays) ? MaxWays : ways_r);
		above = a >> block_bits_r;
		shift = block_bits_r + sbe;
		tg = (shift >= 64) ? 64'd0 : (a >> shift);
		s = int'(above & ((64'd1 << sbe) - 64'd1)) & (NumSets - 1);
		si = s[7:0];
		for (int w = 0; w < nw; w++)
			if (line_ok[s][w] && line_tg[s][w] == tg) begin
				promote(s, w, nw, line_rank[s][w]);
				hits_r = bump(hits_r);
				oc = OUT_HIT;
				return;
			end
		occupied = 0;
		for (int w = 0; w < nw; w++)
			if (line_ok[s][w])
				occupied++;
		misses_r = bump(misses_r);
		if (occupied == nw) begin
			victim = 0;
			best = 0;
			for (int w = 0; w < nw; w++)
				if (w == 0 || line_rank[s][w] > best) begin
					best = line_rank[s][w];
					victim = w;
				end
			line_tg[s][victim] = tg;
			promote(s, victim, nw, best);
			evicts_r = bump(evicts_r);
			oc = OUT_EVICT;
			return;
		end
		for (int w = 0; w < nw; w++)
			if (!line_ok[s][w]) begin
				line_ok[s][w] = 1'b1;
				line_tg[s][w] = tg;
				promote(s, w, nw, AgeMax + 1);
				break;
			end
		oc = OUT_MISS;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		access_result_t r;
		int n;
		if (!arst_n) begin
			set_bits_r <= 4'd4;
			block_bits_r <= 6'd4;
			ways_r <= 4'd1;
			for (int s = 0; s < NumSets; s++)
				for (int w = 0; w < MaxWays; w++) begin
					line_ok[s][w] = 1'b0;
					line_tg[s][w] = 64'd0;
					line_rank[s][w] = 3'd0;
				end
			hits_r = 0;
			misses_r = 0;
			evicts_r = 0;
			result_q.delete();
			errors <= 0;
			checked <= 0;
		end else begin
			if (strobe) begin
				if (result_q.size() == 0) begin
					$display("%0t: unexpected result outcome=%0d set=%0d", $time, outcome, set_index);
					errors <= errors + 1;
				end else begin
					r = result_q.pop_front();
					checked <= checked + 1;
					if (outcome !== r.oc || set_index !== r.si || last !== r.lst
							|| hit_total !== r.hits || miss_total !== r.misses
							|| eviction_total !== r.evicts) begin
						$display("%0t: mismatch expected oc=%0d set=%0d last=%0d h=%0d m=%0d e=%0d",
							$time, r.oc, r.si, r.lst, r.hits, r.misses, r.evicts);
						$display("%0t:          actual   oc=%0d set=%0d last=%0d h=%0d m=%0d e=%0d",
							$time, outcome, set_index, last, hit_total, miss_total, eviction_total);
						errors <= errors + 1;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				case (cfg_index)
					REG_SET_BITS: set_bits_r <= cfg_data[3:0];
					REG_BLOCK_BITS: block_bits_r <= cfg_data;
					REG_WAYS: ways_r <= cfg_data[3:0];
					default: ;
				endcase
			if (start && !busy) begin
				n = (action_t'(action) == ACT_LS) ? 1 : ((action_t'(action) == ACT_MODIFY) ? 2 : 0);
				for (int k = 0; k < n; k++) begin
					cache_lookup(address, r.oc, r.si);
					r.lst = (k == n - 1);
					r.hits = hits_r;
					r.misses = misses_r;
					r.evicts = evicts_r;
					result_q.push_back(r);
				end
			end
		end
	end
endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
module tb;
	import salc_pkg::*;

	localparam logic [1:0] RegUnused = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] action = ACT_LS;
	logic [63:0] address = 64'd0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = REG_SET_BITS;
	logic [5:0] cfg_data = 6'd0;
	logic strobe;
	logic [1:0] outcome;
	logic [7:0] set_index;
	logic last;
	logic [31:0] hit_total, miss_total, eviction_total;
	int errors, pending, checked;
	int sent = 0;
	int settings = 0;
	logic quiet = 1'b0;
	logic [63:0] pool[12];

	always #5 clk = ~clk;

	set_assoc_lru_cache_model dut (.*);

	salc_checker chk (.*);

	task automatic write_reg(input logic [1:0] idx, input logic [5:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Hold the request until accepted, then maybe open a gap.
	task automatic issue(input logic [1:0] act, input logic [63:0] a);
		start <= 1'b1;
		action <= act;
		address <= a;
		do @(posedge clk); while (busy);
		sent++;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0 || busy);
		repeat (12) @(posedge clk);
	endtask

	task automatic setup(input logic [5:0] sb, input logic [5:0] bb, input logic [5:0] wn);
		drain();
		write_reg(REG_BLOCK_BITS, bb);
		write_reg(REG_WAYS, wn);
		write_reg(REG_SET_BITS, sb);
		settings++;
	endtask

	initial begin
		logic [63:0] a;
		logic [1:0] act;
		int pick;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		// defaults first, clearing pass must finish before acceptance
		issue(ACT_LS, 64'd0);
		issue(ACT_LS, 64'd0);
		issue(ACT_MODIFY, '1);
		issue(ACT_IFETCH, 64'h1234);
		issue(ACT_NONE, 64'h5678);
		issue(ACT_LS, 64'h100);
		issue(ACT_MODIFY, 64'h100);
		setup(6'd0, 6'd0, 6'd8);
		write_reg(RegUnused, 6'h3F);
		issue(ACT_LS, 64'd0);
		issue(ACT_LS, '1);
		issue(ACT_MODIFY, 64'h8000_0000_0000_0000);
		issue(ACT_LS, 64'd0);
		setup(6'd15, 6'd63, 6'd15);
		issue(ACT_LS, '1);
		issue(ACT_LS, 64'd0);
		setup(6'd8, 6'd32, 6'd2);
		issue(ACT_LS, 64'h0000_0001_0000_0000);
		issue(ACT_LS, 64'h0000_0101_0000_0000);
		issue(ACT_LS, 64'h0000_0201_0000_0000);
		issue(ACT_MODIFY, 64'h0000_0101_0000_0000);
		// shrink then grow ways to leave equal ranks behind
		setup(6'd8, 6'd32, 6'd0);
		issue(ACT_LS, 64'h0000_0301_0000_0000);
		setup(6'd8, 6'd32, 6'd2);
		issue(ACT_LS, 64'h0000_0401_0000_0000);
		issue(ACT_LS, 64'h0000_0501_0000_0000);

		for (int ph = 0; ph < 10; ph++) begin
			quiet = (ph >= 8);
			case (ph)
				0: setup(6'd0, 6'd0, 6'd1);
				1: setup(6'd8, 6'd63, 6'd8);
				default: setup(6'($urandom_range(0, 15)), 6'(($urandom_range(0, 3) == 0)
					? $urandom_range(0, 63) : $urandom_range(0, 8)),
					6'($urandom_range(0, 15)));
			endcase
			for (int i = 0; i < 12; i++)
				pool[i] = {$urandom, $urandom};
			for (int i = 0; i < 50; i++) begin
				pick = $urandom_range(0, 99);
				act = (pick < 50) ? ACT_LS : ((pick < 88) ? ACT_MODIFY
					: ((pick < 94) ? ACT_IFETCH : ACT_NONE));
				if ($urandom_range(0, 9) == 0)
					a = {$urandom, $urandom};
				else
					a = pool[$urandom_range(0, 11)] ^ 64'($urandom_range(0, 15));
				issue(act, a);
			end
		end
		drain();
		repeat (20) @(posedge clk);
		$display("Sent %0d requests across %0d settings; %0d results checked.",
			sent, settings, checked);
		if (errors == 0)
			$display("set_assoc_lru_cache_model verification clean");
		else
			$display("set_assoc_lru_cache_model verification failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("set_assoc_lru_cache_model verification failed");
		$finish;
	end
endmodule
